// ===== design/kced_pkg.sv =====
`timescale 1ns / 1ps

package kced_pkg;

  localparam int unsigned NumKeysDefault = 4;
  localparam int unsigned PinW           = 4;
  localparam int unsigned KeyIdxW        = 2;
  localparam int unsigned MaskW          = 8;
  localparam int unsigned FlagW          = 7;
  localparam int unsigned TimerW         = 16;
  localparam int unsigned DivW           = 5;
  localparam int unsigned ScanPeriod     = 20;
  localparam int unsigned AddrW          = 4;
  localparam int unsigned DataW          = 32;

  localparam logic OpTick  = 1'b0;
  localparam logic OpCheck = 1'b1;

  localparam int unsigned EvDownBit   = 0;
  localparam int unsigned EvUpBit     = 1;
  localparam int unsigned EvSingleBit = 2;
  localparam int unsigned EvDoubleBit = 3;
  localparam int unsigned EvLongBit   = 4;
  localparam int unsigned EvRepeatBit = 5;
  localparam int unsigned EvHoldBit   = 6;
  localparam int unsigned MaskBadBit  = 7;

  localparam logic [MaskW-1:0] EvHoldMask = 8'h40;

  localparam logic [TimerW-1:0] LongResetVal   = 16'd1000;
  localparam logic [TimerW-1:0] DoubleResetVal = 16'd300;
  localparam logic [TimerW-1:0] RepeatResetVal = 16'd200;

  typedef enum logic [1:0] {
    REG_ACTIVE_HIGH = 2'd0,
    REG_LONG_PRESS  = 2'd1,
    REG_DOUBLE      = 2'd2,
    REG_REPEAT      = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_HOLD = 3'd1,
    PH_WAIT_DBL  = 3'd2,
    PH_WAIT_DUP  = 3'd3,
    PH_REPEAT    = 3'd4
  } phase_e;

  typedef struct packed {
    logic [TimerW-1:0] long_ticks;
    logic [TimerW-1:0] double_ticks;
    logic [TimerW-1:0] repeat_ticks;
  } kced_cfg_t;

  typedef struct packed {
    logic             tick;
    logic             scan;
    logic             check;
    logic [MaskW-1:0] mask;
  } kced_lane_ctrl_t;

endpackage

// ===== design/key_click_event_detector.sv =====
`timescale 1ns / 1ps
// Key click event detector for up to NUM_KEYS push keys.
// Input channel: one transaction is either a tick (op_i low) carrying the raw
// pin levels, or a check (op_i high) naming a key and an event mask.
// Every tick counts the key timers down; every 20th tick samples the pins and
// advances one event state machine per key, each in its own lane.
// A check returns one output transaction whose hit_o tells whether any masked
// event flag of that key was set (never with mask bit 7 set), and on a hit
// clears those flags unless the mask is exactly the held flag. A tick returns
// nothing. A check's result reaches out_valid_o in the next cycle. Unless
// stalled, one transaction is accepted every cycle; an output register sits
// between the two channels. When the receiver stalls, a waiting result holds
// and the input stays ready only while the waiting result is taken in the
// same cycle. Reset clears all flags, timers and state machines and loads the
// register defaults. The APB port is always ready; configure only while idle.

module key_click_event_detector #(
  parameter int unsigned NUM_KEYS = kced_pkg::NumKeysDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [kced_pkg::PinW-1:0]       pin_levels_i,
  input  logic [kced_pkg::KeyIdxW-1:0]    key_index_i,
  input  logic [kced_pkg::MaskW-1:0]      event_mask_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            hit_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kced_pkg::AddrW-1:0]      paddr,
  input  logic [kced_pkg::DataW-1:0]      pwdata,
  output logic [kced_pkg::DataW-1:0]      prdata,
  output logic                            pready
);

  localparam int unsigned NumIdx = 2 ** kced_pkg::KeyIdxW;

  logic [kced_pkg::PinW-1:0]    act_high_q;
  kced_pkg::kced_cfg_t          cfg_q;
  logic [kced_pkg::DivW-1:0]    div_q, div_d;
  logic                         in_fire;
  logic                         tick_fire;
  logic                         chk_fire;
  logic                         scan;
  logic                         cfg_wr;
  logic [1:0]                   reg_idx;
  logic [NUM_KEYS-1:0]          hit_vec;

  assign in_fire   = in_valid_i && in_ready_o;
  assign tick_fire = in_fire && (op_i == kced_pkg::OpTick);
  assign chk_fire  = in_fire && (op_i == kced_pkg::OpCheck);

  assign scan  = tick_fire && (div_q == kced_pkg::DivW'(kced_pkg::ScanPeriod - 1));
  assign div_d = scan ? '0 : div_q + 5'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= '0;
    end else if (tick_fire) begin
      div_q <= div_d;
    end
  end

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_high_q         <= '0;
      cfg_q.long_ticks   <= kced_pkg::LongResetVal;
      cfg_q.double_ticks <= kced_pkg::DoubleResetVal;
      cfg_q.repeat_ticks <= kced_pkg::RepeatResetVal;
    end else if (cfg_wr) begin
      case (reg_idx)
        kced_pkg::REG_ACTIVE_HIGH: begin
          act_high_q <= pwdata[kced_pkg::PinW-1:0];
        end
        kced_pkg::REG_LONG_PRESS: begin
          cfg_q.long_ticks <= pwdata[kced_pkg::TimerW-1:0];
        end
        kced_pkg::REG_DOUBLE: begin
          cfg_q.double_ticks <= pwdata[kced_pkg::TimerW-1:0];
        end
        kced_pkg::REG_REPEAT: begin
          cfg_q.repeat_ticks <= pwdata[kced_pkg::TimerW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      kced_pkg::REG_ACTIVE_HIGH: prdata = kced_pkg::DataW'(act_high_q);
      kced_pkg::REG_LONG_PRESS:  prdata = kced_pkg::DataW'(cfg_q.long_ticks);
      kced_pkg::REG_DOUBLE:      prdata = kced_pkg::DataW'(cfg_q.double_ticks);
      kced_pkg::REG_REPEAT:      prdata = kced_pkg::DataW'(cfg_q.repeat_ticks);
      default:                   prdata = '0;
    endcase
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic                      lvl;
    logic                      act;
    logic                      sel;
    kced_pkg::kced_lane_ctrl_t ctrl;

    if (k < kced_pkg::PinW) begin : g_pin
      assign lvl = pin_levels_i[k];
      assign act = act_high_q[k];
    end else begin : g_nopin
      assign lvl = 1'b0;
      assign act = 1'b0;
    end

    if (k < NumIdx) begin : g_sel
      assign sel = (key_index_i == kced_pkg::KeyIdxW'(k));
    end else begin : g_nosel
      assign sel = 1'b0;
    end

    assign ctrl = {tick_fire, scan, chk_fire && sel, event_mask_i};

    kced_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cfg_i    (cfg_q),
      .ctrl_i   (ctrl),
      .level_i  (lvl),
      .active_i (act),
      .hit_o    (hit_vec[k])
    );
  end

  kced_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .chk_fire_i  (chk_fire),
    .key_index_i (key_index_i),
    .hit_vec_i   (hit_vec),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .hit_o       (hit_o)
  );

`ifndef ASSERT_OFF
  a_check_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_fire |=> out_valid_o)
    else $error("Accepted check transaction did not produce a result.");

  a_tick_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_fire && !out_valid_o |=> !out_valid_o)
    else $error("Tick transaction produced a result.");

  a_bad_mask_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_fire && event_mask_i[kced_pkg::MaskBadBit] |=> !hit_o)
    else $error("Invalid event mask reported a hit.");

  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_q < kced_pkg::DivW'(kced_pkg::ScanPeriod))
    else $error("Scan divider ran past its period.");
`endif

endmodule

// ===== design/kced_lane.sv =====
`timescale 1ns / 1ps

module kced_lane (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kced_pkg::kced_cfg_t        cfg_i,
  input  kced_pkg::kced_lane_ctrl_t  ctrl_i,
  input  logic                       level_i,
  input  logic                       active_i,
  output logic                       hit_o
);

  kced_pkg::phase_e                   phase_q, phase_d;
  logic [kced_pkg::TimerW-1:0]        timer_q, timer_d;
  logic [kced_pkg::TimerW-1:0]        timer_dec;
  logic [kced_pkg::FlagW-1:0]         flags_q, flags_d;
  logic [kced_pkg::FlagW-1:0]         f;
  logic                               last_q, last_d;
  logic                               cur;
  logic                               timer_zero;
  logic                               clear_en;

  assign cur        = (level_i == active_i);
  assign timer_dec  = (timer_q == '0) ? timer_q : timer_q - 16'd1;
  assign timer_zero = (timer_dec == '0);

  assign hit_o    = !ctrl_i.mask[kced_pkg::MaskBadBit] &&
                    (|(flags_q & ctrl_i.mask[kced_pkg::FlagW-1:0]));
  assign clear_en = hit_o && (ctrl_i.mask != kced_pkg::EvHoldMask);

  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    flags_d = flags_q;
    last_d  = last_q;
    f       = flags_q;
    if (ctrl_i.tick) begin
      timer_d = timer_dec;
      if (ctrl_i.scan) begin
        last_d = cur;
        f[kced_pkg::EvHoldBit] = cur;
        if (cur && !last_q) begin
          f[kced_pkg::EvDownBit] = 1'b1;
        end
        if (!cur && last_q) begin
          f[kced_pkg::EvUpBit] = 1'b1;
        end
        case (phase_q)
          kced_pkg::PH_IDLE: begin
            if (cur) begin
              timer_d = cfg_i.long_ticks;
              phase_d = kced_pkg::PH_WAIT_HOLD;
            end
          end
          kced_pkg::PH_WAIT_HOLD: begin
            if (!cur) begin
              timer_d = cfg_i.double_ticks;
              phase_d = kced_pkg::PH_WAIT_DBL;
            end else if (timer_zero) begin
              f[kced_pkg::EvLongBit] = 1'b1;
              timer_d = cfg_i.repeat_ticks;
              phase_d = kced_pkg::PH_REPEAT;
            end
          end
          kced_pkg::PH_WAIT_DBL: begin
            if (cur) begin
              f[kced_pkg::EvDoubleBit] = 1'b1;
              phase_d = kced_pkg::PH_WAIT_DUP;
            end else if (timer_zero) begin
              f[kced_pkg::EvSingleBit] = 1'b1;
              phase_d = kced_pkg::PH_IDLE;
            end
          end
          kced_pkg::PH_WAIT_DUP: begin
            if (!cur) begin
              phase_d = kced_pkg::PH_IDLE;
            end
          end
          kced_pkg::PH_REPEAT: begin
            if (!cur) begin
              phase_d = kced_pkg::PH_IDLE;
            end else if (timer_zero) begin
              f[kced_pkg::EvRepeatBit] = 1'b1;
              timer_d = cfg_i.repeat_ticks;
            end
          end
          default: begin
            phase_d = kced_pkg::PH_IDLE;
          end
        endcase
        flags_d = f;
      end
    end else if (ctrl_i.check && clear_en) begin
      flags_d = flags_q & ~ctrl_i.mask[kced_pkg::FlagW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= kced_pkg::PH_IDLE;
      timer_q <= '0;
      flags_q <= '0;
      last_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      flags_q <= flags_d;
      last_q  <= last_d;
    end
  end

endmodule

// ===== design/kced_merge.sv =====
`timescale 1ns / 1ps

module kced_merge #(
  parameter int unsigned NUM_KEYS = kced_pkg::NumKeysDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          chk_fire_i,
  input  logic [kced_pkg::KeyIdxW-1:0]  key_index_i,
  input  logic [NUM_KEYS-1:0]           hit_vec_i,
  input  logic                          out_ready_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  output logic                          hit_o
);

  localparam int unsigned NumIdx = 2 ** kced_pkg::KeyIdxW;

  logic [NumIdx-1:0] hit_pad;
  logic              valid_q, valid_d;
  logic              hit_q, hit_d;

  for (genvar k = 0; k < NumIdx; k++) begin : g_pad
    if (k < NUM_KEYS) begin : g_key
      assign hit_pad[k] = hit_vec_i[k];
    end else begin : g_none
      assign hit_pad[k] = 1'b0;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    hit_d   = hit_q;
    if (chk_fire_i) begin
      valid_d = 1'b1;
      hit_d   = hit_pad[key_index_i];
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  assign out_valid_o = valid_q;
  assign hit_o       = hit_q;

endmodule

// ===== tb/key_click_event_detector_tb.sv =====
`timescale 1ns / 1ps

module key_click_event_detector_tb;

  localparam int unsigned NumKeys    = kced_pkg::NumKeysDefault;
  localparam int unsigned PinW       = kced_pkg::PinW;
  localparam int unsigned KeyIdxW    = kced_pkg::KeyIdxW;
  localparam int unsigned MaskW      = kced_pkg::MaskW;
  localparam int unsigned FlagW      = kced_pkg::FlagW;
  localparam int unsigned TimerW     = kced_pkg::TimerW;
  localparam int unsigned DivW       = kced_pkg::DivW;
  localparam int unsigned AddrW      = kced_pkg::AddrW;
  localparam int unsigned DataW      = kced_pkg::DataW;
  localparam int unsigned ScanPeriod = kced_pkg::ScanPeriod;
  localparam logic [MaskW-1:0] EvHoldMask = kced_pkg::EvHoldMask;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned LongStall  = 300;
  localparam int unsigned DrainWait  = 5;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_ready_o;
  logic             op_i         = kced_pkg::OpTick;
  logic [PinW-1:0]  pin_levels_i = '0;
  logic [KeyIdxW-1:0] key_index_i = '0;
  logic [MaskW-1:0] event_mask_i = '0;
  logic             out_valid_o;
  logic             out_ready_i  = 1'b0;
  logic             hit_o;
  logic             psel         = 1'b0;
  logic             penable      = 1'b0;
  logic             pwrite       = 1'b0;
  logic [AddrW-1:0] paddr        = '0;
  logic [DataW-1:0] pwdata       = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  key_click_event_detector #(
    .NUM_KEYS(NumKeys)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .pin_levels_i(pin_levels_i),
    .key_index_i (key_index_i),
    .event_mask_i(event_mask_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the block's configuration and per-key state.
  logic [PinW-1:0]   act_mask_cfg = '0;
  logic [TimerW-1:0] long_cfg     = kced_pkg::LongResetVal;
  logic [TimerW-1:0] dbl_cfg      = kced_pkg::DoubleResetVal;
  logic [TimerW-1:0] rpt_cfg      = kced_pkg::RepeatResetVal;

  logic [FlagW-1:0]  key_flags  [NumKeys];
  logic              key_down   [NumKeys];
  kced_pkg::phase_e  key_state  [NumKeys];
  logic [TimerW-1:0] key_tmr    [NumKeys];
  logic [DivW-1:0]   tick_div = '0;

  logic hit_expected[$];
  int   errors = 0;
  int   cycle_count = 0;

  logic idle_on = 1'b0;
  int   stall_token = 0;
  int   stall_seen = 0;
  int   ready_hold = 0;

  int          gen_div = 0;
  logic [3:0]  press_want = '0;
  int          press_left [NumKeys];
  int          max_hold = 4;

  initial begin
    for (int k = 0; k < NumKeys; k++) begin
      key_flags[k]  = '0;
      key_down[k]   = 1'b0;
      key_state[k]  = kced_pkg::PH_IDLE;
      key_tmr[k]    = '0;
      press_left[k] = 0;
    end
  end

  function automatic void scan_one_key(int k, logic [PinW-1:0] pins);
    logic             cur;
    logic             prev;
    logic [FlagW-1:0] f;
    cur  = (pins[k] == act_mask_cfg[k]);
    prev = key_down[k];
    f    = key_flags[k];
    key_down[k] = cur;
    f[kced_pkg::EvHoldBit] = cur;
    if (cur && !prev) f[kced_pkg::EvDownBit] = 1'b1;
    if (!cur && prev) f[kced_pkg::EvUpBit] = 1'b1;
    case (key_state[k])
      kced_pkg::PH_IDLE: begin
        if (cur) begin
          key_tmr[k]   = long_cfg;
          key_state[k] = kced_pkg::PH_WAIT_HOLD;
        end
      end
      kced_pkg::PH_WAIT_HOLD: begin
        if (!cur) begin
          key_tmr[k]   = dbl_cfg;
          key_state[k] = kced_pkg::PH_WAIT_DBL;
        end else if (key_tmr[k] == '0) begin
          f[kced_pkg::EvLongBit] = 1'b1;
          key_tmr[k]   = rpt_cfg;
          key_state[k] = kced_pkg::PH_REPEAT;
        end
      end
      kced_pkg::PH_WAIT_DBL: begin
        if (cur) begin
          f[kced_pkg::EvDoubleBit] = 1'b1;
          key_state[k] = kced_pkg::PH_WAIT_DUP;
        end else if (key_tmr[k] == '0) begin
          f[kced_pkg::EvSingleBit] = 1'b1;
          key_state[k] = kced_pkg::PH_IDLE;
        end
      end
      kced_pkg::PH_WAIT_DUP: begin
        if (!cur) key_state[k] = kced_pkg::PH_IDLE;
      end
      kced_pkg::PH_REPEAT: begin
        if (!cur) begin
          key_state[k] = kced_pkg::PH_IDLE;
        end else if (key_tmr[k] == '0) begin
          f[kced_pkg::EvRepeatBit] = 1'b1;
          key_tmr[k] = rpt_cfg;
        end
      end
      default: key_state[k] = kced_pkg::PH_IDLE;
    endcase
    key_flags[k] = f;
  endfunction

  function automatic void predict_transaction(logic op, logic [PinW-1:0] pins,
                                              logic [KeyIdxW-1:0] idx,
                                              logic [MaskW-1:0] mask);
    logic hit;
    if (op == kced_pkg::OpTick) begin
      for (int k = 0; k < NumKeys; k++)
        if (key_tmr[k] != '0) key_tmr[k] = key_tmr[k] - 1'b1;
      if (tick_div == DivW'(ScanPeriod - 1)) begin
        tick_div = '0;
        for (int k = 0; k < NumKeys; k++) scan_one_key(k, pins);
      end else begin
        tick_div = tick_div + 1'b1;
      end
    end else begin
      hit = 1'b0;
      if (int'(idx) < NumKeys && !mask[kced_pkg::MaskBadBit]) begin
        if ((key_flags[idx] & mask[FlagW-1:0]) != '0) begin
          hit = 1'b1;
          if (mask != EvHoldMask) key_flags[idx] = key_flags[idx] & ~mask[FlagW-1:0];
        end
      end
      hit_expected.push_back(hit);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (hit_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual hit %0b", $time, hit_o);
          errors++;
        end else if (hit_o !== hit_expected[0]) begin
          $display("%0t: hit mismatch, expected %0b, actual %0b",
                   $time, hit_expected[0], hit_o);
          errors++;
          void'(hit_expected.pop_front());
        end else begin
          void'(hit_expected.pop_front());
        end
      end
      if (in_valid_i && in_ready_o)
        predict_transaction(op_i, pin_levels_i, key_index_i, event_mask_i);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (stall_token != stall_seen) begin
      stall_seen = stall_token;
      ready_hold = LongStall;
    end
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready_i <= 1'b0;
    end else if (!idle_on) begin
      out_ready_i <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      ready_hold = idle_gap();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_item(logic op, logic [PinW-1:0] pins, logic [KeyIdxW-1:0] idx,
                           logic [MaskW-1:0] mask);
    int gap;
    gap = idle_on ? idle_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    pin_levels_i <= pins;
    key_index_i  <= idx;
    event_mask_i <= mask;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_tick_pins(logic [PinW-1:0] pins);
    gen_div = (gen_div == ScanPeriod - 1) ? 0 : gen_div + 1;
    send_item(kced_pkg::OpTick, pins, KeyIdxW'($urandom_range(0, 3)),
              MaskW'($urandom_range(0, 255)));
  endtask

  task automatic send_check(logic [KeyIdxW-1:0] idx, logic [MaskW-1:0] mask);
    send_item(kced_pkg::OpCheck, PinW'($urandom_range(0, 15)), idx, mask);
  endtask

  // On a scan tick the pins follow a per-key press pattern held for a few scans,
  // with an occasional noisy sample; other ticks carry random levels.
  task automatic send_random_tick();
    logic [PinW-1:0] pins;
    if (gen_div == ScanPeriod - 1) begin
      for (int k = 0; k < NumKeys; k++) begin
        if (press_left[k] == 0) begin
          press_want[k] = ~press_want[k];
          press_left[k] = $urandom_range(1, max_hold);
        end
        press_left[k]--;
      end
      pins = ~(press_want ^ act_mask_cfg);
      if ($urandom_range(0, 9) == 0) pins = PinW'($urandom_range(0, 15));
    end else begin
      pins = PinW'($urandom_range(0, 15));
    end
    send_tick_pins(pins);
  endtask

  function automatic logic [MaskW-1:0] pick_mask();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return MaskW'($urandom_range(0, 255));
      1: return EvHoldMask;
      2: return 8'h7F;
      3: return MaskW'(8'h80 | $urandom_range(0, 127));
      default: return MaskW'(1 << $urandom_range(0, 6));
    endcase
  endfunction

  task automatic run_traffic(int n, int check_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < check_pct)
        send_check(KeyIdxW'($urandom_range(0, 3)), pick_mask());
      else
        send_random_tick();
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (hit_expected.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(kced_pkg::reg_e r, logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({r, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      kced_pkg::REG_ACTIVE_HIGH: act_mask_cfg = value[PinW-1:0];
      kced_pkg::REG_LONG_PRESS:  long_cfg = value[TimerW-1:0];
      kced_pkg::REG_DOUBLE:      dbl_cfg = value[TimerW-1:0];
      kced_pkg::REG_REPEAT:      rpt_cfg = value[TimerW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [PinW-1:0] act, logic [TimerW-1:0] lng,
                            logic [TimerW-1:0] dbl, logic [TimerW-1:0] rpt);
    wait_idle();
    write_reg(kced_pkg::REG_ACTIVE_HIGH, DataW'(act));
    write_reg(kced_pkg::REG_LONG_PRESS, DataW'(lng));
    write_reg(kced_pkg::REG_DOUBLE, DataW'(dbl));
    write_reg(kced_pkg::REG_REPEAT, DataW'(rpt));
  endtask

  task automatic test_directed_defaults();
    idle_on = 1'b0;
    send_check(2'd0, 8'h7F);
    send_check(2'd3, 8'hFF);
    for (int i = 0; i < ScanPeriod - 1; i++) send_tick_pins(4'hF);
    send_tick_pins(4'b0101);
    send_check(2'd1, EvHoldMask);
    send_check(2'd1, EvHoldMask);
    send_check(2'd1, 8'h41);
    send_check(2'd1, 8'h01);
    send_check(2'd3, 8'h81);
    send_check(2'd3, 8'h00);
    send_check(2'd0, 8'h01);
  endtask

  task automatic test_zero_reloads();
    set_config(4'hF, 16'd0, 16'd0, 16'd0);
    idle_on  = 1'b1;
    max_hold = 3;
    run_traffic(400, 20);
  endtask

  task automatic test_short_timers();
    set_config(PinW'($urandom_range(0, 15)), 16'd60, 16'd40, 16'd20);
    idle_on  = 1'b0;
    max_hold = 6;
    run_traffic(300, 25);
    idle_on = 1'b1;
    run_traffic(300, 25);
  endtask

  task automatic test_output_stall();
    set_config(4'b1010, 16'd40, 16'd30, 16'd20);
    idle_on  = 1'b0;
    max_hold = 5;
    stall_token++;
    run_traffic(300, 50);
  endtask

  task automatic test_max_reloads();
    set_config(4'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    idle_on  = 1'b1;
    max_hold = 4;
    run_traffic(300, 25);
  endtask

  task automatic test_random_configs();
    for (int round = 0; round < 3; round++) begin
      set_config(PinW'($urandom_range(0, 15)), TimerW'($urandom_range(0, 120)),
                 TimerW'($urandom_range(0, 80)), TimerW'($urandom_range(0, 60)));
      idle_on  = ($urandom_range(0, 2) != 0);
      max_hold = $urandom_range(2, 7);
      run_traffic(120, 25);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_defaults();
    test_zero_reloads();
    test_short_timers();
    test_output_stall();
    test_max_reloads();
    test_random_configs();
    wait_idle();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
